@@ rtl/weo_pkg.sv @@
package weo_pkg;

   localparam int SampleBitsDefault = 16;
   localparam int TrigIterDefault   = 16;

   localparam logic signed [31:0] CordicStart = 32'sd652032874;

   typedef enum logic [2:0] {
      CSR_WRAP_LOW  = 3'd0,
      CSR_WRAP_HIGH = 3'd1,
      CSR_SPAN      = 3'd2,
      CSR_DIST      = 3'd3,
      CSR_TURN      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LEFT   = 2'd0,
      OP_RIGHT  = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic sample_left;
      logic sample_right;
      logic update_start;
      logic cordic_step;
      logic mul_a;
      logic mul_b;
      logic mul_c;
      logic mul_d;
      logic mul_e;
      logic apply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cordic_done;
   } status_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] r;
      begin
         case (k)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ rtl/weo_ctrl.sv @@
module weo_ctrl
   import weo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_op,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_TRIG  = 9'b0_0000_0010,
      ST_MULA  = 9'b0_0000_0100,
      ST_MULB  = 9'b0_0000_1000,
      ST_MULC  = 9'b0_0001_0000,
      ST_MULD  = 9'b0_0010_0000,
      ST_MULE  = 9'b0_0100_0000,
      ST_APPLY = 9'b0_1000_0000,
      ST_OUT   = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign accept     = req_tvalid && req_tready;

   // decode commands
   always_comb begin
      cmd              = '0;
      cmd.sample_left  = accept && (req_op == OP_LEFT);
      cmd.sample_right = accept && (req_op == OP_RIGHT);
      cmd.update_start = accept && (req_op == OP_UPDATE);
      cmd.cordic_step  = (state_ff == ST_TRIG);
      cmd.mul_a        = (state_ff == ST_MULA);
      cmd.mul_b        = (state_ff == ST_MULB);
      cmd.mul_c        = (state_ff == ST_MULC);
      cmd.mul_d        = (state_ff == ST_MULD);
      cmd.mul_e        = (state_ff == ST_MULE);
      cmd.apply        = (state_ff == ST_APPLY);
   end

   // advance the sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (cmd.update_start) state_in = ST_TRIG;
         ST_TRIG:  if (status.cordic_done) state_in = ST_MULA;
         ST_MULA:  state_in = ST_MULB;
         ST_MULB:  state_in = ST_MULC;
         ST_MULC:  state_in = ST_MULD;
         ST_MULD:  state_in = ST_MULE;
         ST_MULE:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_OUT;
         ST_OUT:   if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/weo_datapath.sv @@
module weo_datapath
   import weo_pkg::*;
#(
   parameter int SAMPLE_BITS     = SampleBitsDefault,
   parameter int TRIG_ITERATIONS = TrigIterDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [63:0]            pos_x,
   output logic [63:0]            pos_y,
   output logic [15:0]            heading
);

   localparam int IterBits = $clog2(TRIG_ITERATIONS + 1);

   // configuration registers
   logic signed [15:0] wrap_low_ff, wrap_high_ff;
   logic [16:0]        span_ff;
   logic [31:0]        dist_ff, turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_low_ff  <= -16'sd13107;
         wrap_high_ff <= 16'sd13107;
         span_ff      <= 17'd65536;
         dist_ff      <= 32'd1946111;
         turn_ff      <= 32'd2064888;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WRAP_LOW:  wrap_low_ff  <= csr_wdata[15:0];
            CSR_WRAP_HIGH: wrap_high_ff <= csr_wdata[15:0];
            CSR_SPAN:      span_ff      <= csr_wdata[16:0];
            CSR_DIST:      dist_ff      <= csr_wdata;
            CSR_TURN:      turn_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // wheel state
   logic signed [SAMPLE_BITS-1:0] raw_l_ff, raw_r_ff;
   logic signed [15:0]            wraps_l_ff, wraps_r_ff;
   logic signed [39:0]            lat_l_ff, lat_r_ff, prev_l_ff, prev_r_ff;

   logic signed [SAMPLE_BITS-1:0] enc, raw_sel;
   logic signed [15:0]            wraps_sel, wraps_in;
   logic signed [39:0]            latest_in;
   logic signed [56:0]            wrap_prod;
   logic                          below_lo, above_hi, raw_above, raw_below;

   // unwrap the sample for the selected wheel
   always_comb begin
      enc       = sample;
      raw_sel   = cmd.sample_right ? raw_r_ff : raw_l_ff;
      wraps_sel = cmd.sample_right ? wraps_r_ff : wraps_l_ff;
      below_lo  = 33'(signed'(enc)) < 33'(signed'(wrap_low_ff));
      above_hi  = 33'(signed'(enc)) > 33'(signed'(wrap_high_ff));
      raw_above = 33'(signed'(raw_sel)) > 33'(signed'(wrap_high_ff));
      raw_below = 33'(signed'(raw_sel)) < 33'(signed'(wrap_low_ff));
      wraps_in  = wraps_sel;
      if (below_lo && raw_above) wraps_in = wraps_in + 16'sd1;
      if (above_hi && raw_below) wraps_in = wraps_in - 16'sd1;
      wrap_prod = 57'(wraps_in) * 57'(signed'({1'b0, span_ff}));
      latest_in = 40'(wrap_prod) + 40'(enc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_l_ff   <= '0;
         raw_r_ff   <= '0;
         wraps_l_ff <= '0;
         wraps_r_ff <= '0;
         lat_l_ff   <= '0;
         lat_r_ff   <= '0;
      end else if (cmd.sample_left) begin
         raw_l_ff   <= enc;
         wraps_l_ff <= wraps_in;
         lat_l_ff   <= latest_in;
      end else if (cmd.sample_right) begin
         raw_r_ff   <= enc;
         wraps_r_ff <= wraps_in;
         lat_r_ff   <= latest_in;
      end
   end

   // update: deltas, CORDIC, multiplies
   logic signed [40:0] dl, dr;
   logic signed [41:0] sum_ff;
   logic [31:0]        turn_delta_ff;
   logic [1:0]         quad_ff;
   logic signed [32:0] z_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic [IterBits-1:0] it_ff;
   logic [31:0]        ang_ff;
   logic signed [63:0] px_ff, py_ff;

   logic [31:0]        ang_q;
   logic [1:0]         quad_in;
   logic [31:0]        turn_prod;

   // only the low 32 bits of the heading change count
   always_comb begin
      dl        = 41'(lat_l_ff) - 41'(prev_l_ff);
      dr        = 41'(lat_r_ff) - 41'(prev_r_ff);
      quad_in   = 2'((ang_ff + 32'h2000_0000) >> 30);
      ang_q     = ang_ff - {quad_in, 30'd0};
      turn_prod = 32'(dr - dl) * turn_ff;
   end

   logic [4:0]         k;
   logic signed [33:0] xs, ys;
   assign k  = 5'(it_ff);
   assign xs = cx_ff >>> k;
   assign ys = cy_ff >>> k;
   assign status.cordic_done = (it_ff == IterBits'(TRIG_ITERATIONS));

   always_ff @(posedge clock) begin
      if (cmd.update_start) begin
         sum_ff        <= 42'(dl) + 42'(dr);
         turn_delta_ff <= turn_prod;
         quad_ff       <= quad_in;
         z_ff          <= 33'(signed'(ang_q));
         cx_ff         <= 34'(CordicStart);
         cy_ff         <= '0;
         it_ff         <= '0;
      end else if (cmd.cordic_step && !status.cordic_done) begin
         if (!z_ff[32]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            z_ff  <= z_ff - 33'(atan_turn(k));
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            z_ff  <= z_ff + 33'(atan_turn(k));
         end
         it_ff <= it_ff + 1'b1;
      end
   end

   // quadrant fold
   logic signed [34:0] cosv, sinv;
   always_comb begin
      case (quad_ff)
         2'd0:    begin cosv = 35'(cx_ff);  sinv = 35'(cy_ff);  end
         2'd1:    begin cosv = -35'(cy_ff); sinv = 35'(cx_ff);  end
         2'd2:    begin cosv = -35'(cx_ff); sinv = -35'(cy_ff); end
         default: begin cosv = 35'(cy_ff);  sinv = -35'(cx_ff); end
      endcase
   end

   // magnitudes and signs
   logic [41:0] ms;
   logic [33:0] mc, mt;
   logic        neg_x_ff, neg_y_ff;
   assign ms = sum_ff[41] ? 42'(-sum_ff) : 42'(sum_ff);
   assign mc = cosv[34] ? 34'(-cosv) : 34'(cosv);
   assign mt = sinv[34] ? 34'(-sinv) : 34'(sinv);

   // step a: ms * dist (two partials, 32-bit low limb and 10-bit top limb)
   logic [73:0] sd_ff;
   logic [33:0] mc_ff, mt_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [127:0] prx_ff, pry_ff;

   // steps a to e; in c to e, one limb of the travel per cycle times the trig magnitude
   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         plo_ff   <= 64'(ms[31:0]) * 64'(dist_ff);
         phi_ff   <= 64'(ms[41:32]) * 64'(dist_ff);
         mc_ff    <= mc;
         mt_ff    <= mt;
         neg_x_ff <= sum_ff[41] ^ cosv[34];
         neg_y_ff <= sum_ff[41] ^ sinv[34];
      end
      if (cmd.mul_b) begin
         sd_ff <= 74'(plo_ff) + (74'(phi_ff) << 32);
      end
      if (cmd.mul_c) begin
         prx_ff <= 128'(sd_ff[31:0]) * 128'(mc_ff);
         pry_ff <= 128'(sd_ff[31:0]) * 128'(mt_ff);
      end
      if (cmd.mul_d) begin
         prx_ff <= prx_ff + ((128'(sd_ff[63:32]) * 128'(mc_ff)) << 32);
         pry_ff <= pry_ff + ((128'(sd_ff[63:32]) * 128'(mt_ff)) << 32);
      end
      if (cmd.mul_e) begin
         prx_ff <= prx_ff + ((128'(sd_ff[73:64]) * 128'(mc_ff)) << 64);
         pry_ff <= pry_ff + ((128'(sd_ff[73:64]) * 128'(mt_ff)) << 64);
      end
   end

   // round, saturate, accumulate
   function automatic logic signed [63:0] step_pos(
      input logic signed [63:0] pos, input logic [127:0] prod, input logic neg);
      logic [127:0] r;
      logic [65:0]  sum66;
      logic [63:0]  m;
      logic signed [63:0] res;
      begin
         r = (prod + 128'(1 << 30)) >> 31;
         if (prod == '0) begin
            res = pos;
         end else if (r[127:64] != '0) begin
            res = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end else begin
            m = r[63:0];
            if (!neg) sum66 = 66'(pos) + {2'b0, m};
            else      sum66 = 66'(pos) - {2'b0, m};
            if (sum66[65:63] != 3'b000 && sum66[65:63] != 3'b111)
               res = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
               res = sum66[63:0];
         end
         return res;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff     <= '0;
         py_ff     <= '0;
         ang_ff    <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
      end else begin
         if (cmd.update_start) begin
            prev_l_ff <= lat_l_ff;
            prev_r_ff <= lat_r_ff;
         end
         if (cmd.apply) begin
            px_ff  <= step_pos(px_ff, prx_ff, neg_x_ff);
            py_ff  <= step_pos(py_ff, pry_ff, neg_y_ff);
            ang_ff <= ang_ff + turn_delta_ff;
         end
      end
   end

   assign pos_x   = px_ff;
   assign pos_y   = py_ff;
   assign heading = ang_ff[31:16];

endmodule

@@ rtl/wheel_encoder_odometry.sv @@
// Wheel encoder odometry for a differential drive.
// req channel: one word per operation; tuser = operation (0 left sample,
// 1 right sample, 2 pose update, 3 ignored), tdata = raw signed sample.
// rsp channel: one word per pose update only, tdata = pos_x, pos_y,
// heading from bit 0 up (144 bits).
// csr port: write enable, index 0..4 (wrap_low, wrap_high, encoder_span,
// distance_per_tick, turn_per_tick), 32-bit data; write only when idle.
// A pose update runs the CORDIC from accept, one rotation step per
// cycle until TRIG_ITERATIONS steps are done, followed by five
// multiply stages and an accumulate stage before rsp_tvalid. The block
// takes one word at a time; req_tready returns the cycle after the
// result is taken.
// While rsp_tvalid waits on rsp_tready, the result holds and req_tready
// stays low.
// Synchronous reset restores register defaults and clears pose and counts.
module wheel_encoder_odometry
   import weo_pkg::*;
#(
   parameter int SAMPLE_BITS     = SampleBitsDefault,
   parameter int TRIG_ITERATIONS = TrigIterDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,   // sample
   input  logic [1:0]               req_tuser,   // operation
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [143:0]             rsp_tdata,   // pos_x, pos_y, heading
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic [63:0] pos_x, pos_y;
   logic [15:0] heading;

   weo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   weo_datapath #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .cmd       (cmd),
      .status    (status),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .heading   (heading)
   );

   assign rsp_tdata = {heading, pos_y, pos_x};

   // no input taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept during pending result");

   // held result stays stable under stall
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed under stall");

   // at most one of left sample, right sample and update start at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sample_left, cmd.sample_right, cmd.update_start}))
      else $error("conflicting commands");

endmodule

@@ sim/wheel_encoder_odometry_tb.sv @@
module wheel_encoder_odometry_tb;
   import weo_pkg::*;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [15:0]    req_tdata = '0;   // sample[15:0]
   logic [1:0]     req_tuser = '0;   // operation[1:0]
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [143:0]   rsp_tdata;        // pos_x[63:0], pos_y[127:64], heading[143:128]
   logic           csr_we = 1'b0;
   logic [2:0]     csr_index = '0;
   logic [31:0]    csr_wdata = '0;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] y;
      logic [15:0] hdg;
   } pose_t;

   // odometry state mirrored from the block
   logic signed [15:0] thr_low, thr_high;
   logic [16:0]        span;
   logic [31:0]        dist_step, turn_step;
   logic signed [15:0] last_raw [2];
   logic signed [15:0] wrap_cnt [2];
   logic signed [39:0] count_now [2];
   logic signed [39:0] count_prev [2];
   logic signed [63:0] px, py;
   logic [31:0]        angle;

   logic [17:0] pending_words [$];
   pose_t       expected_poses [$];
   int          mismatches = 0;
   int          burst_left = 0, gap_left = 0, stall_phase = 0;
   bit          load_done = 1'b0;

   always #2 clock = ~clock;

   wheel_encoder_odometry dut (.*);

   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int k);
      return v >>> k;
   endfunction

   // quadrant-reduced CORDIC, cosine and sine in Q30
   task automatic sin_cos(input logic [31:0] a, output logic signed [63:0] c,
                          output logic signed [63:0] s);
      logic [1:0]         q;
      logic signed [63:0] z, x, y, nx;
      logic [31:0]        r;
      q = 2'((a + 32'h2000_0000) >> 30);
      r = a - {q, 30'd0};
      z = 64'(signed'(r));
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y  = y + floor_shift(x, i);
            z  = z - 64'(atan_turn(5'(i)));
         end else begin
            nx = x + floor_shift(y, i);
            y  = y - floor_shift(x, i);
            z  = z + 64'(atan_turn(5'(i)));
         end
         x = nx;
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   // saturating position step: |sum|*dist*|trig|/2^31, rounded half away from zero
   function automatic logic signed [63:0] step_pos(logic signed [63:0] pos,
         logic signed [63:0] sum, logic signed [63:0] tv);
      bit           neg;
      logic [63:0]  ms, mt;
      logic [191:0] prod;
      logic signed [65:0] r;
      neg = (sum < 0) != (tv < 0);
      ms = sum < 0 ? -sum : sum;
      mt = tv < 0 ? -tv : tv;
      if (ms == 0 || mt == 0 || dist_step == 0) return pos;
      prod = (192'(ms) * 192'(dist_step)) & ((192'd1 << 128) - 1);
      prod = ((prod * 192'(mt[31:0])) & ((192'd1 << 128) - 1)) + (192'd1 << 30);
      prod = (prod & ((192'd1 << 128) - 1)) >> 31;
      if (prod[191:64] != 0) return neg ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      r = neg ? 66'(pos) - $signed({2'b0, prod[63:0]}) : 66'(pos) + $signed({2'b0, prod[63:0]});
      if (r > 66'sh7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (r < -66'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return r[63:0];
   endfunction

   task automatic predict_word(input logic [17:0] w);
      op_type             op;
      logic signed [15:0] smp;
      logic signed [63:0] dl, dr, c, s;
      logic [63:0]        dt;
      int                 wh;
      pose_t              p;
      op = op_type'(w[1:0]);
      smp = w[17:2];
      if (op == OP_LEFT || op == OP_RIGHT) begin
         wh = (op == OP_RIGHT);
         if (smp < thr_low && last_raw[wh] > thr_high) wrap_cnt[wh] = wrap_cnt[wh] + 1;
         if (smp > thr_high && last_raw[wh] < thr_low) wrap_cnt[wh] = wrap_cnt[wh] - 1;
         last_raw[wh] = smp;
         count_now[wh] = 40'(64'(smp) + 64'(wrap_cnt[wh]) * $signed({47'd0, span}));
      end else if (op == OP_UPDATE) begin
         dl = 64'(count_now[0]) - 64'(count_prev[0]);
         dr = 64'(count_now[1]) - 64'(count_prev[1]);
         count_prev = count_now;
         sin_cos(angle, c, s);
         px = step_pos(px, dl + dr, c);
         py = step_pos(py, dl + dr, s);
         dt = dr - dl;
         angle = angle + 32'(dt * 64'(turn_step));
         p.x = px; p.y = py; p.hdg = angle[31:16];
         expected_poses.push_back(p);
      end
   endtask

   // write one register and update the model copy of it
   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WRAP_LOW:  thr_low = val[15:0];
         CSR_WRAP_HIGH: thr_high = val[15:0];
         CSR_SPAN:      span = val[16:0];
         CSR_DIST:      dist_step = val;
         default:       turn_step = val;
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [17:0] mk(op_type op, logic [15:0] smp);
      return {smp, op};
   endfunction

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_word({req_tdata, req_tuser});
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               {req_tdata, req_tuser} <= pending_words.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(30, 1);
                  gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
               end else burst_left <= burst_left - 1;
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: stall pattern and compare
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_tready <= (stall_phase[8]) ? 1'b1 : (stall_phase % 7 < 4);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pose %h", rsp_tdata);
            end else begin
               pose_t e;
               e = expected_poses.pop_front();
               if (rsp_tdata[63:0] != e.x || rsp_tdata[127:64] != e.y
                     || rsp_tdata[143:128] != e.hdg) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pose mismatch: x %h/%h y %h/%h hdg %h/%h", e.x,
                        rsp_tdata[63:0], e.y, rsp_tdata[127:64], e.hdg, rsp_tdata[143:128]);
               end
            end
         end
      end
   end

   task automatic random_phase(input int n);
      int v;
      for (int i = 0; i < n; i++) begin
         v = $urandom_range(99);
         if (v < 2) pending_words.push_back(mk(OP_NONE, 16'($urandom)));
         else if (v < 20) pending_words.push_back(mk(OP_UPDATE, 16'($urandom)));
         else if (v < 80)
            // random raw samples for either wheel
            pending_words.push_back(mk(op_type'(v & 1), 16'($urandom)));
         else pending_words.push_back(mk(op_type'(v & 1),
            ($urandom_range(1)) ? 16'h7fff - 16'($urandom_range(9000)) :
                                  16'h8000 + 16'($urandom_range(9000))));
      end
   endtask

   initial begin
      thr_low = -16'sd13107; thr_high = 16'sd13107; span = 17'd65536;
      dist_step = 32'd1946111; turn_step = 32'd2064888;
      last_raw = '{0, 0}; wrap_cnt = '{0, 0}; count_now = '{0, 0};
      count_prev = '{0, 0}; px = 0; py = 0; angle = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, wraps, ignored op
      pending_words = '{mk(OP_UPDATE, 16'h1234), mk(OP_LEFT, 16'h7fff),
         mk(OP_RIGHT, 16'h7fff), mk(OP_UPDATE, 0), mk(OP_LEFT, 16'h8000),
         mk(OP_RIGHT, 16'h8000), mk(OP_NONE, 16'hffff), mk(OP_UPDATE, 0),
         mk(OP_RIGHT, 16'h7fff), mk(OP_UPDATE, 0), mk(OP_LEFT, 16'h0000),
         mk(OP_RIGHT, 16'hffff), mk(OP_UPDATE, 16'hffff)};
      drain();
      write_reg(CSR_WRAP_LOW, 32'h0000_1000);
      write_reg(CSR_WRAP_HIGH, 32'h0000_f000);
      write_reg(CSR_SPAN, 32'h0001_ffff);
      write_reg(CSR_DIST, 32'hffff_ffff);
      write_reg(CSR_TURN, 32'hffff_ffff);
      random_phase(300);
      drain();
      write_reg(CSR_WRAP_LOW, 32'h0000_8000);
      write_reg(CSR_WRAP_HIGH, 32'h0000_7fff);
      write_reg(CSR_SPAN, 32'd0);
      write_reg(CSR_DIST, 32'd0);
      write_reg(CSR_TURN, 32'd0);
      random_phase(250);
      drain();
      write_reg(CSR_WRAP_LOW, 32'hffff_cccd);
      write_reg(CSR_WRAP_HIGH, 32'h0000_3333);
      write_reg(CSR_SPAN, 32'd1);
      write_reg(CSR_DIST, 32'd50_000_000);
      write_reg(CSR_TURN, 32'd40_000_000);
      random_phase(500);
      drain();
      write_reg(CSR_SPAN, 32'd65536);
      write_reg(CSR_DIST, 32'd1946111);
      write_reg(CSR_TURN, 32'd2064888);
      random_phase(600);
      drain();
      load_done = 1'b1;
   end

   initial begin
      wait (load_done);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
